[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helper macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Check an implication in the next cycle outside reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

[rtl/lrpf_pkg.sv]
// ---------------------------------------------------------------------------
// lrpf_pkg
// Shared types and constants of the page frame store and line rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none
package lrpf_pkg;
   localparam int ScreenWidth  = 128;
   localparam int ScreenHeight = 64;
   localparam int NumPages     = (ScreenHeight + 7) / 8;
   localparam int StoreBytes   = ScreenWidth * NumPages;
   localparam int AddrW        = $clog2(StoreBytes);

   typedef enum logic [2:0] {
      REQ_LINE  = 3'd0,
      REQ_RECT  = 3'd1,
      REQ_CLEAR = 3'd2,
      REQ_FLUSH = 3'd3,
      REQ_FETCH = 3'd4
   } req_code_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BUSY    = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;
   localparam logic [1:0] ST_NOREAD  = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;      // capture request fields and second endpoint
      logic       seg_init;  // set up straight segment (index in seg_sel)
      logic [2:0] seg_sel;   // 0 line bresenham, 1..4 rectangle sides
      logic       step;      // one pixel step (issue read)
      logic       write;     // write back modified byte
      logic       clr_init;
      logic       clr_step;
      logic       clr_dirty_full;
      logic       flush;
      logic       fetch_rd;
      logic       fetch_done;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic       seg_last;   // current pixel is last of segment
      logic       clr_last;
      logic       active;     // readout active
      logic       empty;      // dirty window empty
   } stat_type;
endpackage
`default_nettype wire

[rtl/lrpf_datapath.sv]
// ---------------------------------------------------------------------------
// lrpf_datapath
// Frame store, Bresenham stepper, dirty window and readout pointers.
// ---------------------------------------------------------------------------
`default_nettype none
module lrpf_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lrpf_pkg::cmd_type cmd,
   output lrpf_pkg::stat_type    stat,
   input  wire logic signed [9:0] x_start,
   input  wire logic signed [9:0] y_start,
   input  wire logic signed [9:0] x_end,
   input  wire logic signed [9:0] y_end,
   input  wire logic signed [9:0] rect_w,
   input  wire logic signed [9:0] rect_h,
   input  wire logic             color,
   output logic [6:0]            win_col_min,
   output logic [6:0]            win_col_max,
   output logic [2:0]            win_page_min,
   output logic [2:0]            win_page_max,
   output logic [7:0]            pixel_byte,
   output logic                  last_byte
);
   import lrpf_pkg::*;

   logic [7:0] mem [StoreBytes];

   // captured request
   logic signed [11:0] xs_ff, ys_ff, x2_ff, y2_ff;
   logic color_ff;
   // stepper: major coordinate a, minor b
   logic signed [11:0] a_ff, a_in, aend_ff, b_ff, b_in;
   logic signed [12:0] err_ff, err_in, dx2_ff, dy2_ff;
   logic steep_ff, brz_ff;
   logic signed [1:0] bstep_ff;
   // pixel in flight
   logic signed [11:0] px_ff, py_ff;
   logic pv_ff;
   logic [AddrW-1:0] waddr_ff;
   logic [2:0] wbit_ff;
   logic [7:0] rdata_ff;
   // dirty window and readout
   logic [7:0] dcmin_ff;
   logic [6:0] dcmax_ff;
   logic [3:0] dpmin_ff;
   logic [2:0] dpmax_ff;
   logic [6:0] lcmin_ff, lcmax_ff, rcol_ff;
   logic [2:0] lpmin_ff, lpmax_ff, rpage_ff;
   logic act_ff;
   logic [AddrW:0] clr_ff;

   logic signed [11:0] cx, cy, sx, sy, ex, ey;
   logic signed [11:0] adx, ady;
   logic on_screen;

   // current pixel coordinates
   assign cx = steep_ff ? b_ff : a_ff;
   assign cy = steep_ff ? a_ff : b_ff;
   assign on_screen = (cx >= 0) && (cx < 12'(ScreenWidth)) &&
                      (cy >= 0) && (cy < 12'(ScreenHeight));

   assign stat.seg_last = (a_ff == aend_ff);
   assign stat.clr_last = (clr_ff == (AddrW+1)'(StoreBytes - 1));
   assign stat.active   = act_ff;
   assign stat.empty    = (dcmin_ff > {1'b0, dcmax_ff}) || (dpmin_ff > {1'b0, dpmax_ff});

   // segment endpoints for straight paths and line
   always_comb begin
      sx = xs_ff; sy = ys_ff; ex = x2_ff; ey = y2_ff;
      case (cmd.seg_sel)
         3'd1: begin sy = ys_ff; ey = ys_ff; end
         3'd2: begin sy = y2_ff; ey = y2_ff; end
         3'd3: begin ex = xs_ff; end
         3'd4: begin sx = x2_ff; end
         default: ;
      endcase
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
   end

   // stepper next values
   always_comb begin
      a_in = a_ff + 12'sd1;
      b_in = b_ff;
      err_in = err_ff + dy2_ff;
      if (!brz_ff && err_ff >= 0) begin
         b_in = b_ff + 12'(bstep_ff);
         err_in = err_ff - dx2_ff + dy2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xs_ff <= 12'(x_start); ys_ff <= 12'(y_start);
         color_ff <= color;
         // rectangle opposite corner or line end chosen by caller path
         x2_ff <= (cmd.seg_sel == 3'd0) ? 12'(x_end) : 12'(x_start) + 12'(rect_w);
         y2_ff <= (cmd.seg_sel == 3'd0) ? 12'(y_end) : 12'(y_start) + 12'(rect_h);
      end
      if (cmd.seg_init) begin
         if (sy == ey || sx == ex) begin
            // straight run: major is the varying axis, ascending
            brz_ff <= 1'b1;
            steep_ff <= (sy != ey);
            if (sy == ey) begin
               a_ff <= (sx < ex) ? sx : ex; aend_ff <= (sx < ex) ? ex : sx; b_ff <= sy;
            end else begin
               a_ff <= (sy < ey) ? sy : ey; aend_ff <= (sy < ey) ? ey : sy; b_ff <= sx;
            end
            err_ff <= '0; dx2_ff <= '0; dy2_ff <= '0; bstep_ff <= 2'sd1;
         end else begin
            brz_ff <= 1'b0;
            steep_ff <= (ady > adx);
            if (ady > adx) begin
               a_ff <= (sy > ey) ? ey : sy; aend_ff <= (sy > ey) ? sy : ey;
               b_ff <= (sy > ey) ? ex : sx;
               bstep_ff <= (((sy > ey) ? ex : sx) < ((sy > ey) ? sx : ex)) ? 2'sd1 : -2'sd1;
               dx2_ff <= 13'(ady) <<< 1; dy2_ff <= 13'(adx) <<< 1;
               err_ff <= (13'(adx) <<< 1) - 13'(ady);
            end else begin
               a_ff <= (sx > ex) ? ex : sx; aend_ff <= (sx > ex) ? sx : ex;
               b_ff <= (sx > ex) ? ey : sy;
               bstep_ff <= (((sx > ex) ? ey : sy) < ((sx > ex) ? sy : ey)) ? 2'sd1 : -2'sd1;
               dx2_ff <= 13'(adx) <<< 1; dy2_ff <= 13'(ady) <<< 1;
               err_ff <= (13'(ady) <<< 1) - 13'(adx);
            end
         end
      end else if (cmd.step) begin
         a_ff <= a_in; b_ff <= b_in; err_ff <= err_in;
      end
      // issue read of the pixel byte
      if (cmd.step) begin
         px_ff <= cx; py_ff <= cy;
         waddr_ff <= AddrW'({cy[5:3], cx[6:0]});
         wbit_ff <= cy[2:0];
      end
      if (cmd.step) rdata_ff <= mem[AddrW'({cy[5:3], cx[6:0]})];
      if (cmd.fetch_rd) pixel_byte <= mem[AddrW'({rpage_ff, rcol_ff})];
      // write back modified byte
      if (cmd.write && pv_ff) begin
         mem[waddr_ff] <= color_ff ? (rdata_ff | (8'd1 << wbit_ff))
                                   : (rdata_ff & ~(8'd1 << wbit_ff));
      end
      if (cmd.clr_step) mem[clr_ff[AddrW-1:0]] <= 8'd0;
   end

   // valid pixel and clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         if (cmd.step) pv_ff <= on_screen;
         if (cmd.clr_init) clr_ff <= '0;
         else if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
      end
   end

   // dirty window, flush latch and readout pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         dcmin_ff <= 8'(ScreenWidth); dcmax_ff <= '0;
         dpmin_ff <= 4'(NumPages); dpmax_ff <= '0;
         act_ff <= 1'b0; rcol_ff <= '0; rpage_ff <= '0;
         lcmin_ff <= '0; lcmax_ff <= '0; lpmin_ff <= '0; lpmax_ff <= '0;
         last_byte <= 1'b0;
      end else begin
         if (cmd.write && pv_ff) begin
            if ({1'b0, px_ff[6:0]} < dcmin_ff) dcmin_ff <= {1'b0, px_ff[6:0]};
            if (px_ff[6:0] > dcmax_ff) dcmax_ff <= px_ff[6:0];
            if ({1'b0, py_ff[5:3]} < dpmin_ff) dpmin_ff <= {1'b0, py_ff[5:3]};
            if (py_ff[5:3] > dpmax_ff) dpmax_ff <= py_ff[5:3];
         end
         if (cmd.clr_dirty_full) begin
            dcmin_ff <= '0; dcmax_ff <= 7'(ScreenWidth - 1);
            dpmin_ff <= '0; dpmax_ff <= 3'(NumPages - 1);
         end
         if (cmd.flush) begin
            lcmin_ff <= dcmin_ff[6:0]; lcmax_ff <= dcmax_ff;
            lpmin_ff <= dpmin_ff[2:0]; lpmax_ff <= dpmax_ff;
            rcol_ff <= dcmin_ff[6:0]; rpage_ff <= dpmin_ff[2:0];
            act_ff <= 1'b1;
            dcmin_ff <= 8'(ScreenWidth); dcmax_ff <= '0;
            dpmin_ff <= 4'(NumPages); dpmax_ff <= '0;
         end
         if (cmd.fetch_rd) begin
            last_byte <= (rcol_ff >= lcmax_ff) && (rpage_ff >= lpmax_ff);
            if (rcol_ff >= lcmax_ff) begin
               if (rpage_ff >= lpmax_ff) begin
                  act_ff <= 1'b0;
               end else begin
                  rpage_ff <= rpage_ff + 3'd1; rcol_ff <= lcmin_ff;
               end
            end else rcol_ff <= rcol_ff + 7'd1;
         end
      end
   end

   assign win_col_min = lcmin_ff;
   assign win_col_max = lcmax_ff;
   assign win_page_min = lpmin_ff;
   assign win_page_max = lpmax_ff;
endmodule
`default_nettype wire

[rtl/lrpf_ctrl.sv]
// ---------------------------------------------------------------------------
// lrpf_ctrl
// Request sequencer: decodes a request and walks segments, clear and readout.
// ---------------------------------------------------------------------------
`default_nettype none
module lrpf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_type,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_status,
   output logic                  sel_win,
   output logic                  sel_byte,
   output lrpf_pkg::cmd_type     cmd,
   input  wire lrpf_pkg::stat_type stat
);
   import lrpf_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_SEG   = 8'b00000010,
      S_RD    = 8'b00000100,
      S_WR    = 8'b00001000,
      S_CLR   = 8'b00010000,
      S_INIT  = 8'b00100000,
      S_RSP   = 8'b01000000,
      S_HOLD  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] seg_ff, seg_in;
   logic rect_ff, rect_in, last_ff, last_in;
   logic [1:0] status_ff, status_in;
   logic win_ff, win_in, byte_ff, byte_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RSP);
   assign rsp_status = status_ff;
   assign sel_win    = win_ff;
   assign sel_byte   = byte_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff; seg_in = seg_ff; rect_in = rect_ff; last_in = last_ff;
      status_in = status_ff; win_in = win_ff; byte_in = byte_ff;
      cmd = '0;
      cmd.seg_sel = seg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_OK; win_in = 1'b0; byte_in = 1'b0;
               state_in = S_RSP;
               if (req_type <= REQ_FLUSH && stat.active) status_in = ST_BUSY;
               else begin
                  case (req_type) inside
                     REQ_LINE, REQ_RECT: begin
                        cmd.load = 1'b1;
                        cmd.seg_sel = (req_type == REQ_RECT) ? 3'd1 : 3'd0;
                        seg_in = (req_type == REQ_RECT) ? 3'd1 : 3'd0;
                        rect_in = (req_type == REQ_RECT);
                        state_in = S_SEG;
                     end
                     REQ_CLEAR: begin
                        cmd.clr_init = 1'b1; state_in = S_CLR;
                     end
                     REQ_FLUSH: begin
                        if (stat.empty) status_in = ST_EMPTY;
                        else begin cmd.flush = 1'b1; win_in = 1'b1; end
                     end
                     REQ_FETCH: begin
                        if (!stat.active) status_in = ST_NOREAD;
                        else begin cmd.fetch_rd = 1'b1; byte_in = 1'b1; end
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_SEG: begin cmd.seg_init = 1'b1; state_in = S_RD; end
         S_RD: begin
            cmd.step = 1'b1; last_in = stat.seg_last; state_in = S_WR;
         end
         S_WR: begin
            cmd.write = 1'b1;
            if (!last_ff) state_in = S_RD;
            else if (rect_ff && seg_ff != 3'd4) begin
               seg_in = seg_ff + 3'd1; state_in = S_SEG;
            end else state_in = S_RSP;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin cmd.clr_dirty_full = 1'b1; state_in = S_RSP; end
         end
         // zero the store once after reset, dirty window untouched
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_RSP: if (rsp_ready) state_in = S_HOLD;
         S_HOLD: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; seg_ff <= '0; rect_ff <= 1'b0; last_ff <= 1'b0;
         status_ff <= ST_OK; win_ff <= 1'b0; byte_ff <= 1'b0;
      end else begin
         state_ff <= state_in; seg_ff <= seg_in; rect_ff <= rect_in; last_ff <= last_in;
         status_ff <= status_in; win_ff <= win_in; byte_ff <= byte_in;
      end
   end
endmodule
`default_nettype wire

[rtl/line_raster_page_framebuffer.sv]
// ---------------------------------------------------------------------------
// line_raster_page_framebuffer
// 128x64 page frame store with line/rectangle drawing and dirty readout.
// ---------------------------------------------------------------------------
// Channel   Direction  Signals
// req       in         req_valid/req_ready, req_type, coordinates, color
// rsp       out        rsp_valid/rsp_ready, status, window, pixel_byte, last
//
// Each pixel is a store read, then a write back, and each segment starts
// with a setup state; a rectangle walks its four sides, each with its own
// setup. Clear walks all 1024 store bytes, one per cycle. Flush and fetch
// answer the next cycle. One request is in flight at a time; the result
// holds until taken, and a hold state follows before the next request
// transfer. Synchronous reset clears control state, then a pass over all
// 1024 store bytes zeroes the store with req_ready low.
`default_nettype none
`include "assert_macros.svh"
module line_raster_page_framebuffer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_type,
   input  wire logic signed [9:0] req_x_start,
   input  wire logic signed [9:0] req_y_start,
   input  wire logic signed [9:0] req_x_end,
   input  wire logic signed [9:0] req_y_end,
   input  wire logic signed [9:0] req_rect_w,
   input  wire logic signed [9:0] req_rect_h,
   input  wire logic             req_color,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [6:0]            rsp_win_col_min,
   output logic [6:0]            rsp_win_col_max,
   output logic [2:0]            rsp_win_page_min,
   output logic [2:0]            rsp_win_page_max,
   output logic [7:0]            rsp_pixel_byte,
   output logic                  rsp_last_byte
);
   import lrpf_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic sel_win, sel_byte;
   logic [6:0] wcmin, wcmax;
   logic [2:0] wpmin, wpmax;
   logic [7:0] pbyte;
   logic lbyte;

   lrpf_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .rsp_valid, .rsp_ready, .rsp_status, .sel_win, .sel_byte, .cmd, .stat
   );

   lrpf_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .x_start(req_x_start), .y_start(req_y_start),
      .x_end(req_x_end), .y_end(req_y_end),
      .rect_w(req_rect_w), .rect_h(req_rect_h), .color(req_color),
      .win_col_min(wcmin), .win_col_max(wcmax),
      .win_page_min(wpmin), .win_page_max(wpmax),
      .pixel_byte(pbyte), .last_byte(lbyte)
   );

   // zero fields that the request did not produce
   assign rsp_win_col_min  = sel_win ? wcmin : '0;
   assign rsp_win_col_max  = sel_win ? wcmax : '0;
   assign rsp_win_page_min = sel_win ? wpmin : '0;
   assign rsp_win_page_max = sel_win ? wpmax : '0;
   assign rsp_pixel_byte   = sel_byte ? pbyte : '0;
   assign rsp_last_byte    = sel_byte ? lbyte : 1'b0;

   `CHK_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `CHK_IMPL(a_win_ok, clock, reset, rsp_valid && sel_win, rsp_status == ST_OK)
   `CHK_NEXT(a_rsp_gone, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
endmodule
`default_nettype wire

[verif/line_raster_page_framebuffer_tb.sv]
// ---------------------------------------------------------------------------
// line_raster_page_framebuffer_tb
// Self-checking bench for the page frame store: draws lines and rectangles,
// clears, flushes and fetches the dirty window, and compares every response
// with a behavioral copy of the store, dirty window and readout state.
// ---------------------------------------------------------------------------
`default_nettype none

// Fields of one request, coordinates already sign extended
typedef struct {
   logic [2:0] kind;
   int         xs, ys, xe, ye, rw, rh;
   bit         color;
} draw_req_t;

// Fields of one response
typedef struct {
   logic [1:0] status;
   logic [6:0] col_min, col_max;
   logic [2:0] page_min, page_max;
   logic [7:0] pixel;
   logic       last;
} frame_rsp_t;

class frame_scoreboard;
   logic [7:0] store [lrpf_pkg::StoreBytes];
   int         dcol_min, dcol_max, dpage_min, dpage_max;
   bit         readout_on;
   int         rd_col, rd_page;
   int         lw_col_min, lw_col_max, lw_page_min, lw_page_max;
   frame_rsp_t awaited [$];
   int         errors;
   int         n_draw, n_flush, n_fetch, n_busy;

   function new();
      foreach (store[i]) store[i] = '0;
      reset_window();
      readout_on = 0;
      rd_col = 0;
      rd_page = 0;
      errors = 0;
   endfunction

   function void reset_window();
      dcol_min  = lrpf_pkg::ScreenWidth;
      dcol_max  = 0;
      dpage_min = lrpf_pkg::NumPages;
      dpage_max = 0;
   endfunction

   // set or clear one pixel, skip it when off the screen
   function void put_pixel(int x, int y, bit color);
      int pg;
      int idx;
      if (x < 0 || x >= lrpf_pkg::ScreenWidth || y < 0 || y >= lrpf_pkg::ScreenHeight)
         return;
      pg = y >> 3;
      if (x < dcol_min) dcol_min = x;
      if (x > dcol_max) dcol_max = x;
      if (pg < dpage_min) dpage_min = pg;
      if (pg > dpage_max) dpage_max = pg;
      idx = pg * lrpf_pkg::ScreenWidth + x;
      store[idx][y & 7] = color;
   endfunction

   function void span_h(int xa, int xb, int y, bit color);
      int t;
      if (xa > xb) begin
         t = xa; xa = xb; xb = t;
      end
      for (t = xa; t <= xb; t++) put_pixel(t, y, color);
   endfunction

   function void span_v(int x, int ya, int yb, bit color);
      int t;
      if (ya > yb) begin
         t = ya; ya = yb; yb = t;
      end
      for (t = ya; t <= yb; t++) put_pixel(x, t, color);
   endfunction

   // Bresenham with steep and reversed swaps, straight runs taken directly
   function void raster_line(int x0, int y0, int x1, int y1, bit color);
      int adx, ady, t, dx, dy, y, err, stp;
      bit steep;
      steep = 0;
      if (y0 == y1) begin
         span_h(x0, x1, y0, color);
         return;
      end
      if (x0 == x1) begin
         span_v(x0, y0, y1, color);
         return;
      end
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      if (ady > adx) begin
         t = x0; x0 = y0; y0 = t;
         t = x1; x1 = y1; y1 = t;
         steep = 1;
      end
      if (x0 > x1) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end
      dx  = x1 - x0;
      dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
      stp = (y0 < y1) ? 1 : -1;
      y   = y0;
      err = 2 * dy - dx;
      for (int i = 0; i <= dx; i++) begin
         if (steep) put_pixel(y, x0 + i, color);
         else put_pixel(x0 + i, y, color);
         if (err >= 0) begin
            y += stp;
            err -= 2 * dx;
         end
         err += 2 * dy;
      end
   endfunction

   // update the state for one accepted transfer and queue its response
   function void note_request(draw_req_t r);
      frame_rsp_t e;
      e = '{default: '0};
      if (r.kind <= lrpf_pkg::REQ_FLUSH && readout_on) begin
         e.status = lrpf_pkg::ST_BUSY;
         n_busy++;
      end else begin
         case (r.kind)
            lrpf_pkg::REQ_LINE: begin
               raster_line(r.xs, r.ys, r.xe, r.ye, r.color);
               n_draw++;
            end
            lrpf_pkg::REQ_RECT: begin
               span_h(r.xs, r.xs + r.rw, r.ys, r.color);
               span_h(r.xs, r.xs + r.rw, r.ys + r.rh, r.color);
               span_v(r.xs, r.ys, r.ys + r.rh, r.color);
               span_v(r.xs + r.rw, r.ys, r.ys + r.rh, r.color);
               n_draw++;
            end
            lrpf_pkg::REQ_CLEAR: begin
               foreach (store[i]) store[i] = '0;
               dcol_min  = 0;
               dcol_max  = lrpf_pkg::ScreenWidth - 1;
               dpage_min = 0;
               dpage_max = lrpf_pkg::NumPages - 1;
            end
            lrpf_pkg::REQ_FLUSH: begin
               if (dcol_min > dcol_max || dpage_min > dpage_max) begin
                  e.status = lrpf_pkg::ST_EMPTY;
               end else begin
                  lw_col_min  = dcol_min;
                  lw_col_max  = dcol_max;
                  lw_page_min = dpage_min;
                  lw_page_max = dpage_max;
                  reset_window();
                  readout_on = 1;
                  rd_col     = lw_col_min;
                  rd_page    = lw_page_min;
                  e.col_min  = lw_col_min[6:0];
                  e.col_max  = lw_col_max[6:0];
                  e.page_min = lw_page_min[2:0];
                  e.page_max = lw_page_max[2:0];
                  n_flush++;
               end
            end
            lrpf_pkg::REQ_FETCH: begin
               if (!readout_on) begin
                  e.status = lrpf_pkg::ST_NOREAD;
               end else begin
                  e.pixel = store[rd_page * lrpf_pkg::ScreenWidth + rd_col];
                  n_fetch++;
                  if (rd_col >= lw_col_max) begin
                     if (rd_page >= lw_page_max) begin
                        e.last = 1;
                        readout_on = 0;
                     end else begin
                        rd_page++;
                        rd_col = lw_col_min;
                     end
                  end else begin
                     rd_col++;
                  end
               end
            end
            default: ;
         endcase
      end
      awaited.push_back(e);
   endfunction

   function void cmp(string name, int expv, int actv);
      if (expv != actv) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, expv, actv);
         errors++;
      end
   endfunction

   // compare one accepted response with the oldest expectation
   function void check_result(frame_rsp_t a);
      frame_rsp_t e;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected response, expected none actual status %0d",
                  $time, a.status);
         errors++;
         return;
      end
      e = awaited.pop_front();
      cmp("status", e.status, a.status);
      cmp("win_col_min", e.col_min, a.col_min);
      cmp("win_col_max", e.col_max, a.col_max);
      cmp("win_page_min", e.page_min, a.page_min);
      cmp("win_page_max", e.page_max, a.page_max);
      cmp("pixel_byte", e.pixel, a.pixel);
      cmp("last_byte", e.last, a.last);
   endfunction
endclass

module line_raster_page_framebuffer_tb;
   import lrpf_pkg::*;

   localparam int IdleLimit = 40000;
   localparam int ItemGoal  = 290;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [2:0]       req_type = '0;
   logic signed [9:0] req_x_start = '0, req_y_start = '0, req_x_end = '0;
   logic signed [9:0] req_y_end = '0, req_rect_w = '0, req_rect_h = '0;
   logic             req_color = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_status;
   logic [6:0]       rsp_win_col_min, rsp_win_col_max;
   logic [2:0]       rsp_win_page_min, rsp_win_page_max;
   logic [7:0]       rsp_pixel_byte;
   logic             rsp_last_byte;

   frame_scoreboard sb = new();
   int  snd_idle_pct = 14;
   int  rcv_idle_pct = 70;
   int  items_sent = 0;
   int  quiet_cycles = 0;

   line_raster_page_framebuffer uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // check accepted responses
   always @(posedge clock) begin
      frame_rsp_t a;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            a.status   = rsp_status;
            a.col_min  = rsp_win_col_min;
            a.col_max  = rsp_win_col_max;
            a.page_min = rsp_win_page_min;
            a.page_max = rsp_win_page_max;
            a.pixel    = rsp_pixel_byte;
            a.last     = rsp_last_byte;
            sb.check_result(a);
         end
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // drive one request, hold it until the transfer, then note it
   task automatic send(logic [2:0] kind, int xs, int ys, int xe, int ye,
                       int rw, int rh, bit color);
      int gap;
      draw_req_t r;
      gap = 0;
      while ($urandom_range(99) < snd_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type    <= kind;
      req_x_start <= xs[9:0];
      req_y_start <= ys[9:0];
      req_x_end   <= xe[9:0];
      req_y_end   <= ye[9:0];
      req_rect_w  <= rw[9:0];
      req_rect_h  <= rh[9:0];
      req_color   <= color;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      r.kind  = req_type;
      r.xs    = req_x_start;
      r.ys    = req_y_start;
      r.xe    = req_x_end;
      r.ye    = req_y_end;
      r.rw    = req_rect_w;
      r.rh    = req_rect_h;
      r.color = req_color;
      sb.note_request(r);
      items_sent++;
      if (items_sent == ItemGoal / 3) begin
         snd_idle_pct = 70;
         rcv_idle_pct = 14;
      end else if (items_sent == 2 * ItemGoal / 3) begin
         snd_idle_pct = 0;
         rcv_idle_pct = 0;
      end
   endtask

   task automatic simple(logic [2:0] kind);
      send(kind, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
           $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
           $urandom_range(1));
   endtask

   // fetch until the readout window is exhausted
   task automatic drain_readout();
      while (sb.readout_on) simple(REQ_FETCH);
   endtask

   // coordinate near a center
   function automatic int coord(int center, int spread);
      return center + $urandom_range(2 * spread) - spread;
   endfunction

   // small shape around a batch center, so the flushed window stays small
   task automatic random_draw(int cx, int cy);
      if ($urandom_range(1))
         send(REQ_LINE, coord(cx, 6), coord(cy, 4), coord(cx, 6), coord(cy, 4),
              $urandom_range(1023), $urandom_range(1023), $urandom_range(3) != 0);
      else
         send(REQ_RECT, coord(cx, 5), coord(cy, 3), $urandom_range(1023),
              $urandom_range(1023), coord(0, 6), coord(0, 4), $urandom_range(3) != 0);
   endtask

   initial begin
      int cx, cy;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty flush and idle fetch
      simple(REQ_FLUSH);
      simple(REQ_FETCH);
      // point, straight runs, both slopes, reversed ends, erase, unknown codes
      send(REQ_LINE, 5, 5, 5, 5, 0, 0, 1);
      send(REQ_LINE, 20, 3, 10, 3, 0, 0, 1);
      send(REQ_LINE, 7, 14, 7, 2, 0, 0, 1);
      send(REQ_LINE, 15, 7, 3, 1, 0, 0, 1);
      send(REQ_LINE, 9, 1, 12, 13, 0, 0, 1);
      send(REQ_RECT, 18, 7, 0, 0, -4, -3, 1);
      send(REQ_LINE, 20, 3, 10, 3, 0, 0, 0);
      send(3'd5, 0, 0, 0, 0, 0, 0, 0);
      send(3'd7, -1, -1, -1, -1, -1, -1, 1);
      send(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
      // refused while the readout runs
      simple(REQ_LINE);
      simple(REQ_RECT);
      simple(REQ_CLEAR);
      simple(REQ_FLUSH);
      drain_readout();
      // off-screen clipping and 10-bit extremes
      send(REQ_LINE, -5, -3, 10, 6, 0, 0, 1);
      send(REQ_LINE, 511, -512, -512, 511, 0, 0, 1);
      send(REQ_RECT, -10, -10, 0, 0, 20, 15, 1);
      send(REQ_RECT, -512, -512, 0, 0, 511, 511, 1);
      send(REQ_RECT, 511, 511, 0, 0, 511, 511, 0);
      send(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
      drain_readout();
      // right and bottom edges
      send(REQ_RECT, 120, 60, 0, 0, 30, 30, 1);
      send(REQ_LINE, 125, 63, 135, 58, 0, 0, 1);
      send(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
      drain_readout();
      simple(REQ_FLUSH);

      // random: draw batches, flush, fetch, with noise mixed in
      while (items_sent < ItemGoal - 12) begin
         cx = $urandom_range(135) - 4;
         cy = $urandom_range(71) - 4;
         repeat ($urandom_range(3, 1)) random_draw(cx, cy);
         if ($urandom_range(9) == 0) simple(3'($urandom_range(7, 5)));
         if ($urandom_range(14) == 0) simple(REQ_FETCH);
         simple(REQ_FLUSH);
         repeat ($urandom_range(2)) begin
            if (sb.readout_on) simple(3'($urandom_range(3)));
            if (sb.readout_on) simple(REQ_FETCH);
         end
         drain_readout();
      end

      // clear marks the whole screen dirty; read the first bytes back
      send(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0);
      simple(REQ_LINE);
      repeat (8) simple(REQ_FETCH);
      req_valid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d requests: %0d draws, %0d flushes, %0d bytes fetched,",
               items_sent, sb.n_draw, sb.n_flush, sb.n_fetch);
      $display("and %0d requests refused while a readout was running.", sb.n_busy);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/lrpf_pkg.sv
rtl/lrpf_datapath.sv
rtl/lrpf_ctrl.sv
rtl/line_raster_page_framebuffer.sv
verif/line_raster_page_framebuffer_tb.sv
